/* sv/chc_pkg.sv */
package chc_pkg;

	localparam int DEF_MIN_INTERVAL = 100;
	localparam int DEF_CORDIC_STEPS = 16;

	localparam int TABLE_LEN = 24;
	localparam int STEP_W    = $clog2(TABLE_LEN);

	localparam int FIELD_W   = 16;
	localparam int OFS_W     = FIELD_W + 1;
	localparam int PROD_W    = FIELD_W + OFS_W;
	localparam int SUM_W     = PROD_W + 1;
	localparam int CAL_SHIFT = 8;
	localparam int VEC_W     = 44;
	localparam int VEC_EXT   = VEC_W - SUM_W - CAL_SHIFT;
	localparam int ANG_W     = 26;
	localparam int HEAD_W    = 15;
	localparam int HSUM_W    = HEAD_W + 1;
	localparam int RND_SHIFT = 10;

	localparam logic [HSUM_W-1:0] FULL_TURN = 16'd23040;
	localparam logic signed [ANG_W-1:0] Z_QUARTER = 26'sd5898240;
	localparam logic signed [ANG_W-1:0] Z_HALF_LSB = 26'sd512;

	localparam logic signed [ANG_W-1:0] ATAN_Q16 [TABLE_LEN] = '{
		26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945,
		26'sd234379,  26'sd117266,  26'sd58666,  26'sd29335,
		26'sd14668,   26'sd7334,    26'sd3667,   26'sd1833,
		26'sd917,     26'sd458,     26'sd229,    26'sd115,
		26'sd57,      26'sd29,      26'sd14,     26'sd7,
		26'sd4,       26'sd2,       26'sd1,      26'sd0
	};

	localparam int ADDR_W = 5;

	typedef enum logic [2:0] {
		REG_OFFSET_X       = 3'd0,
		REG_OFFSET_Y       = 3'd1,
		REG_IRON_XX        = 3'd2,
		REG_IRON_XY        = 3'd3,
		REG_IRON_YX        = 3'd4,
		REG_IRON_YY        = 3'd5,
		REG_DECLINATION    = 3'd6,
		REG_SENSOR_PRESENT = 3'd7
	} reg_index_t;

	localparam logic [FIELD_W-1:0] RST_OFFSET_X    = 16'hFCFD;
	localparam logic [FIELD_W-1:0] RST_OFFSET_Y    = 16'hF983;
	localparam logic [FIELD_W-1:0] RST_IRON_XX     = 16'h4117;
	localparam logic [FIELD_W-1:0] RST_IRON_XY     = 16'hF917;
	localparam logic [FIELD_W-1:0] RST_IRON_YX     = 16'hF917;
	localparam logic [FIELD_W-1:0] RST_IRON_YY     = 16'h4062;
	localparam logic [HEAD_W-1:0]  RST_DECLINATION = 15'd658;

	typedef struct packed {
		logic signed [FIELD_W-1:0] offset_x;
		logic signed [FIELD_W-1:0] offset_y;
		logic signed [FIELD_W-1:0] iron_xx;
		logic signed [FIELD_W-1:0] iron_xy;
		logic signed [FIELD_W-1:0] iron_yx;
		logic signed [FIELD_W-1:0] iron_yy;
		logic [HEAD_W-1:0]         declination;
		logic                      sensor_present;
	} chc_cfg_t;

	typedef enum logic [1:0] {
		KIND_ERR   = 2'd0,
		KIND_STALE = 2'd1,
		KIND_CALC  = 2'd2
	} result_kind_t;

	typedef enum logic [1:0] {
		TERM_XX = 2'd0,
		TERM_XY = 2'd1,
		TERM_YX = 2'd2,
		TERM_YY = 2'd3
	} mul_term_t;

	typedef struct packed {
		logic              capture;
		logic              take_time;
		logic              mul_en;
		mul_term_t         mul_idx;
		logic              pre;
		logic              rot;
		logic [STEP_W-1:0] step;
		logic              round;
		logic              decl;
		logic              wrap;
		logic              load_out;
		result_kind_t      out_kind;
	} chc_cmd_t;

	typedef struct packed {
		logic present;
		logic too_soon;
		logic vec_zero;
		logic out_free;
	} chc_status_t;

endpackage

/* sv/compass_heading_calibrated.sv */
// Calibrated compass heading. Each sample transfer (mag_x, mag_y, time_ms) yields
// exactly one result transfer (heading in 1/64 degree, stale, sensor_error).
// Calibration and declination sit in APB registers at byte offsets 0x00..0x1C
// (offset_x, offset_y, iron_xx, iron_xy, iron_yx, iron_yy, declination,
// sensor_present); write them only while the block is idle. A computed sample
// passes four times through the single 16x17 multiplier and then through the
// one-step-per-cycle CORDIC loop before result_valid rises; a zero vector skips
// the loop. A stale or sensor-error result goes from the check straight to the
// output stage. The result sits in an output register, so the next sample is
// taken while an earlier result waits.
module compass_heading_calibrated #(
	parameter int MIN_INTERVAL = chc_pkg::DEF_MIN_INTERVAL,
	parameter int CORDIC_STEPS = chc_pkg::DEF_CORDIC_STEPS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [chc_pkg::ADDR_W-1:0]          paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready,
	input  logic                                sample_valid,
	output logic                                sample_stall,
	input  logic signed [chc_pkg::FIELD_W-1:0]  mag_x,
	input  logic signed [chc_pkg::FIELD_W-1:0]  mag_y,
	input  logic [31:0]                         time_ms,
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic [chc_pkg::HEAD_W-1:0]          heading,
	output logic                                stale,
	output logic                                sensor_error
);
	import chc_pkg::*;

	chc_cfg_t    cfg;
	chc_cmd_t    cmd;
	chc_status_t status;

	chc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	chc_ctrl #(
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.status       (status),
		.cmd          (cmd)
	);

	chc_dp #(
		.MIN_INTERVAL (MIN_INTERVAL)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.cmd          (cmd),
		.status       (status),
		.mag_x        (mag_x),
		.mag_y        (mag_y),
		.time_ms      (time_ms),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.heading      (heading),
		.stale        (stale),
		.sensor_error (sensor_error)
	);

endmodule

/* sv/chc_regs.sv */
module chc_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [chc_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output chc_pkg::chc_cfg_t           cfg
);
	import chc_pkg::*;

	chc_cfg_t   cfg_q;
	reg_index_t idx;
	logic       wr_en;

	assign idx    = reg_index_t'(paddr[ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.offset_x       <= RST_OFFSET_X;
			cfg_q.offset_y       <= RST_OFFSET_Y;
			cfg_q.iron_xx        <= RST_IRON_XX;
			cfg_q.iron_xy        <= RST_IRON_XY;
			cfg_q.iron_yx        <= RST_IRON_YX;
			cfg_q.iron_yy        <= RST_IRON_YY;
			cfg_q.declination    <= RST_DECLINATION;
			cfg_q.sensor_present <= 1'b0;
		end else if (wr_en) begin
			case (idx)
				REG_OFFSET_X:       cfg_q.offset_x       <= pwdata[FIELD_W-1:0];
				REG_OFFSET_Y:       cfg_q.offset_y       <= pwdata[FIELD_W-1:0];
				REG_IRON_XX:        cfg_q.iron_xx        <= pwdata[FIELD_W-1:0];
				REG_IRON_XY:        cfg_q.iron_xy        <= pwdata[FIELD_W-1:0];
				REG_IRON_YX:        cfg_q.iron_yx        <= pwdata[FIELD_W-1:0];
				REG_IRON_YY:        cfg_q.iron_yy        <= pwdata[FIELD_W-1:0];
				REG_DECLINATION:    cfg_q.declination    <= pwdata[HEAD_W-1:0];
				REG_SENSOR_PRESENT: cfg_q.sensor_present <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_OFFSET_X:       prdata = {16'd0, cfg_q.offset_x};
			REG_OFFSET_Y:       prdata = {16'd0, cfg_q.offset_y};
			REG_IRON_XX:        prdata = {16'd0, cfg_q.iron_xx};
			REG_IRON_XY:        prdata = {16'd0, cfg_q.iron_xy};
			REG_IRON_YX:        prdata = {16'd0, cfg_q.iron_yx};
			REG_IRON_YY:        prdata = {16'd0, cfg_q.iron_yy};
			REG_DECLINATION:    prdata = {17'd0, cfg_q.declination};
			REG_SENSOR_PRESENT: prdata = {31'd0, cfg_q.sensor_present};
			default:            prdata = 32'd0;
		endcase
	end

endmodule

/* sv/chc_ctrl.sv */
module chc_ctrl #(
	parameter int CORDIC_STEPS = chc_pkg::DEF_CORDIC_STEPS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 sample_valid,
	output logic                 sample_stall,
	input  chc_pkg::chc_status_t status,
	output chc_pkg::chc_cmd_t    cmd
);
	import chc_pkg::*;

	typedef enum logic [9:0] {
		ST_IDLE  = 10'b0000000001,
		ST_CHECK = 10'b0000000010,
		ST_MUL   = 10'b0000000100,
		ST_ACC   = 10'b0000001000,
		ST_PRE   = 10'b0000010000,
		ST_ROT   = 10'b0000100000,
		ST_ROUND = 10'b0001000000,
		ST_DECL  = 10'b0010000000,
		ST_WRAP  = 10'b0100000000,
		ST_EMIT  = 10'b1000000000
	} state_t;

	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

	state_t            state_q, state_d;
	mul_term_t         mul_q, mul_d;
	logic [STEP_W-1:0] step_q, step_d;
	result_kind_t      kind_q, kind_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mul_q   <= TERM_XX;
			step_q  <= '0;
			kind_q  <= KIND_ERR;
		end else begin
			state_q <= state_d;
			mul_q   <= mul_d;
			step_q  <= step_d;
			kind_q  <= kind_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		mul_d        = mul_q;
		step_d       = step_q;
		kind_d       = kind_q;
		cmd          = '0;
		cmd.mul_idx  = mul_q;
		cmd.step     = step_q;
		cmd.out_kind = kind_q;
		sample_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				sample_stall = 1'b0;
				if (sample_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (!status.present) begin
					kind_d  = KIND_ERR;
					state_d = ST_EMIT;
				end else if (status.too_soon) begin
					kind_d  = KIND_STALE;
					state_d = ST_EMIT;
				end else begin
					cmd.take_time = 1'b1;
					kind_d        = KIND_CALC;
					mul_d         = TERM_XX;
					state_d       = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul_en = 1'b1;
				if (mul_q == TERM_YY) begin
					state_d = ST_ACC;
				end else begin
					mul_d = mul_term_t'(mul_q + 2'd1);
				end
			end
			ST_ACC: begin
				state_d = ST_PRE;
			end
			ST_PRE: begin
				cmd.pre = 1'b1;
				step_d  = '0;
				state_d = status.vec_zero ? ST_ROUND : ST_ROT;
			end
			ST_ROT: begin
				cmd.rot = 1'b1;
				if (step_q == LAST_STEP) begin
					state_d = ST_ROUND;
				end else begin
					step_d = step_q + 1'b1;
				end
			end
			ST_ROUND: begin
				cmd.round = 1'b1;
				state_d   = ST_DECL;
			end
			ST_DECL: begin
				cmd.decl = 1'b1;
				state_d  = ST_WRAP;
			end
			ST_WRAP: begin
				cmd.wrap = 1'b1;
				state_d  = ST_EMIT;
			end
			ST_EMIT: begin
				if (status.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

`ifndef SYNTHESIS
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ROT |-> step_q <= LAST_STEP)
		else $error("rotation step beyond table");

	a_mul_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL && $past(state_q) == ST_CHECK)
		|-> $past(status.present && !status.too_soon))
		else $error("computation started on a sample that must not update");

	a_zero_skip: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND && $past(state_q) == ST_PRE) |-> $past(status.vec_zero))
		else $error("rotation skipped for a nonzero vector");
`endif

endmodule

/* sv/chc_dp.sv */
module chc_dp #(
	parameter int MIN_INTERVAL = chc_pkg::DEF_MIN_INTERVAL
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  chc_pkg::chc_cfg_t                   cfg,
	input  chc_pkg::chc_cmd_t                   cmd,
	output chc_pkg::chc_status_t                status,
	input  logic signed [chc_pkg::FIELD_W-1:0]  mag_x,
	input  logic signed [chc_pkg::FIELD_W-1:0]  mag_y,
	input  logic [31:0]                         time_ms,
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic [chc_pkg::HEAD_W-1:0]          heading,
	output logic                                stale,
	output logic                                sensor_error
);
	import chc_pkg::*;

	logic signed [OFS_W-1:0]   ox_q, oy_q;
	logic [31:0]               time_q, last_time_q;
	logic [HEAD_W-1:0]         held_q;

	logic signed [FIELD_W-1:0] mul_a;
	logic signed [OFS_W-1:0]   mul_b;
	logic signed [PROD_W-1:0]  prod;
	logic signed [PROD_W-1:0]  prod_s1, acc_q;
	mul_term_t                 mul_idx_s1;
	logic                      mul_vld_s1;
	logic signed [SUM_W-1:0]   sum;
	logic signed [SUM_W-1:0]   cx_q, cy_q;

	logic signed [VEC_W-1:0]   cx_w, cy_w, xs, ys;
	logic signed [VEC_W-1:0]   x_q, y_q;
	logic signed [ANG_W-1:0]   z_q, atan_v, z_rnd;
	logic signed [HSUM_W-1:0]  rnd;
	logic [HSUM_W-1:0]         hsum_q, dsum, wsum;

	logic                      result_valid_q, stale_q, err_q;
	logic [HEAD_W-1:0]         heading_q;

	assign status.present  = cfg.sensor_present;
	assign status.too_soon = (time_q - last_time_q) < 32'(MIN_INTERVAL);
	assign status.vec_zero = (cx_q == '0) && (cy_q == '0);
	assign status.out_free = !result_valid_q || !result_stall;

	always_comb begin
		case (cmd.mul_idx)
			TERM_XX: begin mul_a = cfg.iron_xx; mul_b = ox_q; end
			TERM_XY: begin mul_a = cfg.iron_xy; mul_b = oy_q; end
			TERM_YX: begin mul_a = cfg.iron_yx; mul_b = ox_q; end
			TERM_YY: begin mul_a = cfg.iron_yy; mul_b = oy_q; end
			default: begin mul_a = cfg.iron_xx; mul_b = ox_q; end
		endcase
	end

	assign prod = mul_a * mul_b;
	assign sum  = SUM_W'(acc_q) + SUM_W'(prod_s1);

	assign cx_w   = {{VEC_EXT{cx_q[SUM_W-1]}}, cx_q, {CAL_SHIFT{1'b0}}};
	assign cy_w   = {{VEC_EXT{cy_q[SUM_W-1]}}, cy_q, {CAL_SHIFT{1'b0}}};
	assign xs     = x_q >>> cmd.step;
	assign ys     = y_q >>> cmd.step;
	assign atan_v = ATAN_Q16[cmd.step];

	assign z_rnd = z_q + Z_HALF_LSB;
	assign rnd   = HSUM_W'(z_rnd >>> RND_SHIFT);
	assign dsum  = hsum_q + HSUM_W'(cfg.declination);
	assign wsum  = (hsum_q >= FULL_TURN) ? hsum_q - FULL_TURN : hsum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_vld_s1     <= 1'b0;
			last_time_q    <= '0;
			held_q         <= '0;
			result_valid_q <= 1'b0;
		end else begin
			mul_vld_s1 <= cmd.mul_en;
			if (cmd.take_time) begin
				last_time_q <= time_q;
			end
			if (cmd.load_out) begin
				result_valid_q <= 1'b1;
				if (cmd.out_kind == KIND_CALC) begin
					held_q <= hsum_q[HEAD_W-1:0];
				end
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			ox_q   <= OFS_W'(mag_x) - OFS_W'(cfg.offset_x);
			oy_q   <= OFS_W'(mag_y) - OFS_W'(cfg.offset_y);
			time_q <= time_ms;
		end
		if (cmd.mul_en) begin
			prod_s1    <= prod;
			mul_idx_s1 <= cmd.mul_idx;
		end
		if (mul_vld_s1) begin
			case (mul_idx_s1)
				TERM_XX: acc_q <= prod_s1;
				TERM_XY: cx_q  <= sum;
				TERM_YX: acc_q <= prod_s1;
				TERM_YY: cy_q  <= sum;
				default: acc_q <= prod_s1;
			endcase
		end
		if (cmd.pre) begin
			if (cx_q[SUM_W-1]) begin
				if (!cy_q[SUM_W-1]) begin
					x_q <= cy_w;
					y_q <= -cx_w;
					z_q <= Z_QUARTER;
				end else begin
					x_q <= -cy_w;
					y_q <= cx_w;
					z_q <= -Z_QUARTER;
				end
			end else begin
				x_q <= cx_w;
				y_q <= cy_w;
				z_q <= '0;
			end
		end else if (cmd.rot) begin
			if (!y_q[VEC_W-1]) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + atan_v;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - atan_v;
			end
		end
		if (cmd.round) begin
			hsum_q <= rnd[HSUM_W-1] ? HSUM_W'(rnd + signed'(FULL_TURN)) : HSUM_W'(rnd);
		end else if (cmd.decl) begin
			hsum_q <= (dsum >= FULL_TURN) ? dsum - FULL_TURN : dsum;
		end else if (cmd.wrap) begin
			hsum_q <= wsum;
		end
		if (cmd.load_out) begin
			case (cmd.out_kind)
				KIND_ERR: begin
					heading_q <= '0;
					stale_q   <= 1'b0;
					err_q     <= 1'b1;
				end
				KIND_STALE: begin
					heading_q <= held_q;
					stale_q   <= 1'b1;
					err_q     <= 1'b0;
				end
				default: begin
					heading_q <= hsum_q[HEAD_W-1:0];
					stale_q   <= 1'b0;
					err_q     <= 1'b0;
				end
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign heading      = heading_q;
	assign stale        = stale_q;
	assign sensor_error = err_q;

`ifndef SYNTHESIS
	a_held_range: assert property (@(posedge clk) disable iff (!arst_n)
		HSUM_W'(held_q) < FULL_TURN)
		else $error("held heading out of range");

	a_valid_source: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && !$past(result_valid_q)) |-> $past(cmd.load_out))
		else $error("result presented without a load");

	a_time_update: assert property (@(posedge clk) disable iff (!arst_n)
		(last_time_q != $past(last_time_q)) |-> $past(cmd.take_time))
		else $error("sample time changed outside a computed sample");
`endif

endmodule

/* dv/heading_checker.sv */
`timescale 1ns / 100ps

module heading_checker #(
	parameter int MIN_GAP   = 100,
	parameter int ROT_STEPS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic                               pready,
	input  logic [chc_pkg::ADDR_W-1:0]         paddr,
	input  logic [31:0]                        pwdata,
	input  logic                               sample_valid,
	input  logic                               sample_stall,
	input  logic signed [chc_pkg::FIELD_W-1:0] mag_x,
	input  logic signed [chc_pkg::FIELD_W-1:0] mag_y,
	input  logic [31:0]                        time_ms,
	input  logic                               result_valid,
	input  logic                               result_stall,
	input  logic [chc_pkg::HEAD_W-1:0]         heading,
	input  logic                               stale,
	input  logic                               sensor_error,
	output int                                 fail_count,
	output int                                 pending
);
	import chc_pkg::*;

	typedef struct packed {
		logic [HEAD_W-1:0] heading;
		logic              stale;
		logic              sensor_error;
	} compass_out_t;

	localparam longint DEG_TURN = 23040;
	localparam longint ANGLE_STEP [24] = '{
		2949120, 1740967, 919879, 466945, 234379, 117266, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115,
		57, 29, 14, 7, 4, 2, 1, 0
	};

	logic signed [15:0] ofs_x, ofs_y, m_xx, m_xy, m_yx, m_yy;
	logic [14:0]        decl;
	logic               present;
	logic [31:0]        last_fix_ms;
	logic [HEAD_W-1:0]  held;
	compass_out_t       heading_due [$];
	int                 mismatches;

	function automatic longint atan2_q16(input longint x_in, input longint y_in);
		longint x, y, z, t, xs, ys;
		x = x_in;
		y = y_in;
		z = 0;
		if (x == 0 && y == 0)
			return 0;
		if (x < 0) begin
			if (y >= 0) begin
				t = y;
				y = -x;
				x = t;
				z = 90 * 65536;
			end else begin
				t = -y;
				y = x;
				x = t;
				z = -90 * 65536;
			end
		end
		for (int i = 0; i < ROT_STEPS && i < 24; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys;
				y = y - xs;
				z = z + ANGLE_STEP[i];
			end else begin
				x = x - ys;
				y = y + xs;
				z = z - ANGLE_STEP[i];
			end
		end
		return z;
	endfunction

	function automatic compass_out_t predict_heading(input logic signed [15:0] mx,
			input logic signed [15:0] my, input logic [31:0] now);
		compass_out_t r;
		logic [31:0]  gap;
		longint       ox, oy, cx, cy, h;
		r = '0;
		gap = now - last_fix_ms;
		if (!present) begin
			r.sensor_error = 1'b1;
			return r;
		end
		if (gap < 32'(MIN_GAP)) begin
			r.heading = held;
			r.stale = 1'b1;
			return r;
		end
		ox = longint'(mx) - longint'(ofs_x);
		oy = longint'(my) - longint'(ofs_y);
		cx = (longint'(m_xx) * ox + longint'(m_xy) * oy) * 256;
		cy = (longint'(m_yx) * ox + longint'(m_yy) * oy) * 256;
		h = (atan2_q16(cx, cy) + 512) >>> 10;
		if (h < 0)
			h = h + DEG_TURN;
		h = h + longint'(decl);
		while (h >= DEG_TURN)
			h = h - DEG_TURN;
		r.heading = HEAD_W'(h);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		compass_out_t want, got;
		if (!arst_n) begin
			ofs_x = -16'sd771;
			ofs_y = -16'sd1661;
			m_xx = 16'sd16663;
			m_xy = -16'sd1769;
			m_yx = -16'sd1769;
			m_yy = 16'sd16482;
			decl = 15'd658;
			present = 1'b0;
			last_fix_ms = '0;
			held = '0;
			heading_due.delete();
			mismatches = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_index_t'(paddr[4:2]))
					REG_OFFSET_X:       ofs_x = pwdata[15:0];
					REG_OFFSET_Y:       ofs_y = pwdata[15:0];
					REG_IRON_XX:        m_xx = pwdata[15:0];
					REG_IRON_XY:        m_xy = pwdata[15:0];
					REG_IRON_YX:        m_yx = pwdata[15:0];
					REG_IRON_YY:        m_yy = pwdata[15:0];
					REG_DECLINATION:    decl = pwdata[14:0];
					REG_SENSOR_PRESENT: present = pwdata[0];
					default: ;
				endcase
			end
			if (sample_valid && !sample_stall) begin
				want = predict_heading(mag_x, mag_y, time_ms);
				if (!want.stale && !want.sensor_error) begin
					last_fix_ms = time_ms;
					held = want.heading;
				end
				heading_due.push_back(want);
			end
			if (result_valid && !result_stall) begin
				got = {heading, stale, sensor_error};
				if (heading_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected result: heading %0d stale %0b error %0b",
							$time, got.heading, got.stale, got.sensor_error);
				end else begin
					want = heading_due.pop_front();
					if (got.heading !== want.heading || got.stale !== want.stale ||
							got.sensor_error !== want.sensor_error) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: expected heading %0d stale %0b error %0b, got %0d %0b %0b",
								$time, want.heading, want.stale, want.sensor_error,
								got.heading, got.stale, got.sensor_error);
					end
				end
			end
			fail_count <= mismatches;
			pending <= heading_due.size();
		end
	end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps

module testbench;
	import chc_pkg::*;

	localparam int MIN_GAP   = 100;
	localparam int ROT_STEPS = 16;
	localparam int LIMIT     = 600000;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      psel = 1'b0;
	logic                      penable = 1'b0;
	logic                      pwrite = 1'b0;
	logic [ADDR_W-1:0]         paddr = '0;
	logic [31:0]               pwdata = '0;
	logic [31:0]               prdata;
	logic                      pready;
	logic                      sample_valid = 1'b0;
	logic                      sample_stall;
	logic signed [FIELD_W-1:0] mag_x = '0;
	logic signed [FIELD_W-1:0] mag_y = '0;
	logic [31:0]               time_ms = '0;
	logic                      result_valid;
	logic                      result_stall = 1'b0;
	logic [HEAD_W-1:0]         heading;
	logic                      stale;
	logic                      sensor_error;

	int                        fail_count;
	int                        pending;
	int                        send_idle = 35;
	int                        stall_pct = 73;
	int unsigned               cycles = 0;
	logic [31:0]               clock_ms = '0;
	logic signed [15:0]        cur_ofs_x = -16'sd771;
	logic signed [15:0]        cur_ofs_y = -16'sd1661;

	always #10 clk = ~clk;

	compass_heading_calibrated #(
		.MIN_INTERVAL(MIN_GAP),
		.CORDIC_STEPS(ROT_STEPS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.mag_x(mag_x),
		.mag_y(mag_y),
		.time_ms(time_ms),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.heading(heading),
		.stale(stale),
		.sensor_error(sensor_error)
	);

	heading_checker #(
		.MIN_GAP(MIN_GAP),
		.ROT_STEPS(ROT_STEPS)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.pready(pready),
		.paddr(paddr),
		.pwdata(pwdata),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.mag_x(mag_x),
		.mag_y(mag_y),
		.time_ms(time_ms),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.heading(heading),
		.stale(stale),
		.sensor_error(sensor_error),
		.fail_count(fail_count),
		.pending(pending)
	);

	always @(negedge clk) begin
		result_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("compass_heading_calibrated: mismatch");
			$finish;
		end
	end

	task automatic apb_write(input reg_index_t idx, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic write_setting(input logic signed [15:0] ox, input logic signed [15:0] oy,
			input logic signed [15:0] xx, input logic signed [15:0] xy,
			input logic signed [15:0] yx, input logic signed [15:0] yy,
			input logic [14:0] dec, input logic pres);
		apb_write(REG_OFFSET_X, {{16{ox[15]}}, ox});
		apb_write(REG_OFFSET_Y, {{16{oy[15]}}, oy});
		apb_write(REG_IRON_XX, {{16{xx[15]}}, xx});
		apb_write(REG_IRON_XY, {{16{xy[15]}}, xy});
		apb_write(REG_IRON_YX, {{16{yx[15]}}, yx});
		apb_write(REG_IRON_YY, {{16{yy[15]}}, yy});
		apb_write(REG_DECLINATION, {17'd0, dec});
		apb_write(REG_SENSOR_PRESENT, {31'd0, pres});
		cur_ofs_x = ox;
		cur_ofs_y = oy;
	endtask

	task automatic put_sample(input logic signed [15:0] x, input logic signed [15:0] y,
			input logic [31:0] t);
		while ($urandom_range(99) < send_idle) begin
			sample_valid <= 1'b0;
			@(negedge clk);
		end
		sample_valid <= 1'b1;
		mag_x <= x;
		mag_y <= y;
		time_ms <= t;
		do @(posedge clk); while (sample_stall);
		@(negedge clk);
	endtask

	// hold the sender until every transfer in has its result
	task automatic drain();
		sample_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic random_items(input int count);
		logic signed [15:0] x, y;
		int                 pick;
		for (int n = 0; n < count; n++) begin
			if (n == count / 2 || $urandom_range(59) == 0)
				drain();
			pick = $urandom_range(99);
			if (pick < 60) begin
				x = 16'($urandom);
				y = 16'($urandom);
			end else if (pick < 85) begin
				x = cur_ofs_x + 16'($urandom_range(4000)) - 16'd2000;
				y = cur_ofs_y + 16'($urandom_range(4000)) - 16'd2000;
			end else if (pick < 95) begin
				x = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
				y = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
			end else begin
				x = cur_ofs_x;
				y = cur_ofs_y;
			end
			pick = $urandom_range(99);
			if (pick < 45)
				clock_ms = clock_ms + $urandom_range(400, 100);
			else if (pick < 70)
				clock_ms = clock_ms + $urandom_range(99);
			else if (pick < 80)
				clock_ms = clock_ms + ($urandom_range(1) ? 32'd99 : 32'd100);
			else if (pick < 90)
				clock_ms = $urandom;
			else
				clock_ms = clock_ms + $urandom_range(2000, 400);
			put_sample(x, y, clock_ms);
		end
	endtask

	initial begin
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		put_sample(16'sh1234, -16'sd1, 32'd0);
		put_sample(16'sh7FFF, 16'sh8000, 32'd5000);
		drain();
		apb_write(REG_SENSOR_PRESENT, 32'd1);

		put_sample(16'sd0, 16'sd0, 32'd50);
		put_sample(-16'sd771, -16'sd1661, 32'd100);
		put_sample(16'sh7FFF, 16'sh7FFF, 32'd200);
		put_sample(16'sh8000, 16'sh8000, 32'd300);
		put_sample(16'sh7FFF, 16'sh8000, 32'd400);
		put_sample(16'sh8000, 16'sh7FFF, 32'd500);
		put_sample(16'sd1000, -16'sd1661, 32'd600);
		put_sample(-16'sd2000, -16'sd1661, 32'd700);
		put_sample(-16'sd771, 16'sd5000, 32'd800);
		put_sample(-16'sd771, -16'sd8000, 32'd899);
		put_sample(-16'sd771, -16'sd8000, 32'd900);
		put_sample(16'sd0, 16'sd0, 32'hFFFF_FFF0);
		put_sample(16'sd5, 16'sd5, 32'h0000_0010);
		put_sample(16'sd5, 16'sd5, 32'h0000_0060);
		put_sample(-16'sd1, 16'sd0, 32'hFFFF_FFFF);
		clock_ms = 32'hFFFF_FFFF;

		for (int s = 0; s < 6; s++) begin
			if (s == 2) begin
				send_idle = 73;
				stall_pct = 35;
			end
			if (s == 4) begin
				send_idle = 0;
				stall_pct = 0;
			end
			drain();
			case (s)
				0: write_setting(-16'sd771, -16'sd1661, 16'sd16663, -16'sd1769, -16'sd1769,
					16'sd16482, 15'($urandom_range(23039)), 1'b1);
				1: write_setting(16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000,
					16'sh7FFF, 15'h7FFF, 1'b1);
				2: write_setting(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom), 16'($urandom), 15'd23039, 1'b1);
				3: write_setting(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom), 16'($urandom), 15'($urandom_range(23039)), 1'b0);
				4: write_setting(16'sh7FFF, 16'sh8000, 16'sd16384, 16'sd0, 16'sd0,
					-16'sd16384, 15'd0, 1'b1);
				default: write_setting(16'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom), 16'($urandom), 16'($urandom), 15'($urandom), 1'b1);
			endcase
			random_items(s == 3 ? 40 : 140);
		end

		drain();
		repeat (ROT_STEPS + 16) @(negedge clk);
		if (fail_count == 0)
			$display("compass_heading_calibrated: match");
		else
			$display("compass_heading_calibrated: mismatch");
		$finish;
	end

endmodule

/* filelist.f */
sv/chc_pkg.sv
sv/chc_regs.sv
sv/chc_ctrl.sv
sv/chc_dp.sv
sv/compass_heading_calibrated.sv
dv/heading_checker.sv
dv/testbench.sv
